@@ sv/bclp_pkg.sv @@
// Shared types, codes and constants for the button click and long-press classifier.
`default_nettype none
package bclp_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int NUM_KEYS   = 4;

    // event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_SINGLE = 3'd1;
    localparam logic [2:0] EV_LONG   = 3'd2;
    localparam logic [2:0] EV_CLEAR  = 3'd3;
    localparam logic [2:0] EV_MORE   = 3'd4;
    localparam logic [2:0] EV_FEWER  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] CFG_CLICK_WIN   = 2'd1;
    localparam logic [1:0] CFG_CLEAR_COUNT = 2'd2;

    localparam logic [15:0] LONG_PRESS_RST  = 16'd3000;
    localparam logic [15:0] CLICK_WIN_RST   = 16'd300;
    localparam logic [7:0]  CLEAR_COUNT_RST = 8'd3;
    localparam logic [7:0]  TALLY_MAX       = 8'd255;

    typedef enum logic [3:0] {
        MODE_RELEASED = 4'b0001,
        MODE_PRESSED  = 4'b0010,
        MODE_WAITING  = 4'b0100,
        MODE_LONG     = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] click_window_ms;
        logic [7:0]  clear_click_count;
    } cfg_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] now_ms;
        logic [3:0]            pressed_mask;
    } in_item_t;

    typedef struct packed {
        logic [2:0] key0_event;
        logic [2:0] key1_event;
        logic [2:0] key2_event;
        logic [2:0] key3_event;
        logic [7:0] key0_clicks;
        logic [7:0] key1_clicks;
        logic [7:0] key2_clicks;
        logic [7:0] key3_clicks;
    } out_item_t;

endpackage
`default_nettype wire

@@ sv/button_click_long_press_classifier.sv @@
// Top level: input and result registers, configuration registers, four button machines.
//
// Four-button click and long-press classifier. Each item is one tick: a 32-bit
// millisecond timestamp and the pressed levels of four buttons; each tick gives
// one result item with an event code and a click count per button. An item
// waits in the input register until the result register is free, then moves on
// to the result register, which drives m_valid. One item is taken per cycle as
// long as the result side keeps up (the result register frees the input stage
// in the same cycle it is read).
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// should change only while no item is in flight; index 3 is ignored.
`default_nettype none
module button_click_long_press_classifier (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bclp_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bclp_pkg::out_item_t      m_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata
);
    import bclp_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg, out_next;
    logic      out_valid_reg;
    logic      advance;
    logic [2:0] ev [NUM_KEYS];
    logic [7:0] clk_cnt [NUM_KEYS];

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms     <= LONG_PRESS_RST;
            cfg_reg.click_window_ms   <= CLICK_WIN_RST;
            cfg_reg.clear_click_count <= CLEAR_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LONG_PRESS:  cfg_reg.long_press_ms     <= cfg_wdata;
                CFG_CLICK_WIN:   cfg_reg.click_window_ms   <= cfg_wdata;
                CFG_CLEAR_COUNT: cfg_reg.clear_click_count <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        bclp_key u_key (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .step       (advance),
            .now_ms     (in_data_reg.now_ms),
            .pressed    (in_data_reg.pressed_mask[k]),
            .cfg        (cfg_reg),
            .key_event  (ev[k]),
            .key_clicks (clk_cnt[k])
        );
    end

    always_comb begin
        out_next.key0_event  = ev[0];
        out_next.key1_event  = ev[1];
        out_next.key2_event  = ev[2];
        out_next.key3_event  = ev[3];
        out_next.key0_clicks = clk_cnt[0];
        out_next.key1_clicks = clk_cnt[1];
        out_next.key2_clicks = clk_cnt[2];
        out_next.key3_clicks = clk_cnt[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/bclp_key.sv @@
// Per-button state machine: mode, press/release time, click tally and event decode.
`default_nettype none
module bclp_key (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic [bclp_pkg::TIME_WIDTH-1:0] now_ms,
    input  wire logic                           pressed,
    input  wire bclp_pkg::cfg_t                 cfg,
    output logic [2:0]                          key_event,
    output logic [7:0]                          key_clicks
);
    import bclp_pkg::*;

    mode_t                 mode_reg, mode_next;
    logic [TIME_WIDTH-1:0] time_reg, time_next;
    logic [7:0]            tally_reg, tally_next;
    logic                  long_reg, long_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  in_window;

    assign elapsed   = now_ms - time_reg;
    assign in_window = elapsed <= TIME_WIDTH'(cfg.click_window_ms);

    always_comb begin
        mode_next  = mode_reg;
        time_next  = time_reg;
        tally_next = tally_reg;
        long_next  = long_reg;
        key_event  = EV_NONE;
        key_clicks = 8'd0;
        unique case (mode_reg)
            MODE_RELEASED: begin
                if (pressed) begin
                    mode_next = MODE_PRESSED;
                    time_next = now_ms;
                end
            end
            MODE_PRESSED: begin
                if (!pressed) begin
                    mode_next = MODE_WAITING;
                    time_next = now_ms;
                end else if (!long_reg && elapsed >= TIME_WIDTH'(cfg.long_press_ms)) begin
                    mode_next = MODE_LONG;
                    long_next = 1'b1;
                    key_event = EV_LONG;
                end
            end
            MODE_WAITING: begin
                // re-press keeps the release time as the hold reference
                if (pressed && in_window) begin
                    mode_next = MODE_PRESSED;
                    if (tally_reg != TALLY_MAX) begin
                        tally_next = tally_reg + 8'd1;
                    end
                end else if (!in_window) begin
                    if (tally_reg == 8'd0) begin
                        key_event = EV_SINGLE;
                    end else begin
                        key_clicks = tally_reg;
                        if (tally_reg == cfg.clear_click_count) begin
                            key_event = EV_CLEAR;
                        end else if (tally_reg > cfg.clear_click_count) begin
                            key_event = EV_MORE;
                        end else begin
                            key_event = EV_FEWER;
                        end
                    end
                    tally_next = 8'd0;
                    mode_next  = MODE_RELEASED;
                end
            end
            MODE_LONG: begin
                if (!pressed) begin
                    mode_next = MODE_RELEASED;
                    time_next = now_ms;
                    long_next = 1'b0;
                end
            end
            default: begin
                mode_next = MODE_RELEASED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_RELEASED;
            time_reg  <= '0;
            tally_reg <= '0;
            long_reg  <= 1'b0;
        end else if (step) begin
            mode_reg  <= mode_next;
            time_reg  <= time_next;
            tally_reg <= tally_next;
            long_reg  <= long_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/bclp_chk.sv @@
// Port-level checker for the classifier, with its bind statement.
`default_nettype none
module bclp_chk (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire bclp_pkg::out_item_t m_data
);
    import bclp_pkg::*;

    logic multi0, multi1, multi2, multi3;
    assign multi0 = m_data.key0_event == EV_CLEAR || m_data.key0_event == EV_MORE
                 || m_data.key0_event == EV_FEWER;
    assign multi1 = m_data.key1_event == EV_CLEAR || m_data.key1_event == EV_MORE
                 || m_data.key1_event == EV_FEWER;
    assign multi2 = m_data.key2_event == EV_CLEAR || m_data.key2_event == EV_MORE
                 || m_data.key2_event == EV_FEWER;
    assign multi3 = m_data.key3_event == EV_CLEAR || m_data.key3_event == EV_MORE
                 || m_data.key3_event == EV_FEWER;

    // no result item straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result item dropped or changed");

    // clicks carried only by multi-click events, and never zero there
    a_clicks_tie: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (multi0 == (m_data.key0_clicks != 8'd0))
                 && (multi1 == (m_data.key1_clicks != 8'd0))
                 && (multi2 == (m_data.key2_clicks != 8'd0))
                 && (multi3 == (m_data.key3_clicks != 8'd0)))
        else $error("click count does not match event");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.key0_event <= EV_FEWER && m_data.key1_event <= EV_FEWER
                 && m_data.key2_event <= EV_FEWER && m_data.key3_event <= EV_FEWER)
        else $error("event code out of range");

endmodule

bind button_click_long_press_classifier bclp_chk u_bclp_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
